// File: rtl/wesu_pkg.sv
// shared types and constants for the wheel energy/speed update block
package wesu_pkg;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] y;
    logic        c;   // carry out on add, borrow on sub
  } alu_rsp_t;

  typedef enum logic [1:0] {
    CFG_INERTIA = 2'd0,
    CFG_AXIS_X  = 2'd1,
    CFG_AXIS_Y  = 2'd2,
    CFG_AXIS_Z  = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] INERTIA_RST = 32'h1000_0000;
  localparam logic [15:0] AXIS_X_RST  = 16'h4000;
  localparam logic [30:0] U_MAX       = 31'h4000_0000;
  localparam logic [63:0] D_CLAMP     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;
  localparam logic [47:0] E_MAX       = 48'hFFFF_FFFF_FFFF;

endpackage

// File: rtl/wesu_alu.sv
// shared arithmetic unit: 32x32 multiplier and 64-bit add/subtract
module wesu_alu (
  input  wesu_pkg::alu_req_t req,
  output wesu_pkg::alu_rsp_t rsp
);
  import wesu_pkg::*;

  logic [64:0] sum;
  logic [64:0] dif;
  logic [63:0] prod;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  assign dif  = {1'b0, req.a} - {1'b0, req.b};
  assign prod = req.a[31:0] * req.b[31:0];

  always_comb begin
    case (req.op)
      ALU_MUL: begin
        rsp.y = prod;
        rsp.c = 1'b0;
      end
      ALU_ADD: begin
        rsp.y = sum[63:0];
        rsp.c = sum[64];
      end
      ALU_SUB: begin
        rsp.y = dif[63:0];
        rsp.c = dif[64];
      end
      default: begin
        rsp.y = 64'd0;
        rsp.c = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/wheel_energy_speed_update.sv
// top level: sequencer, state and registers of the wheel energy/speed update
// the update uses the bit-serial divider (63 steps for work/inertia, 31 per axis component)
// and two 32-step square roots, all on one shared multiply/add/subtract unit
// a new work value is taken only in idle, once the previous result is loaded;
// a result left waiting stalls the input
// reset (rst_n low, synchronous): speed zero, registers to defaults, no result pending
module wheel_energy_speed_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_work_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_speed_out,
  output logic        [47:0] out_energy_out,
  output logic signed [47:0] out_momentum_x,
  output logic signed [47:0] out_momentum_y,
  output logic signed [47:0] out_momentum_z,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_wdata
);
  import wesu_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'd1,
    S_SQV  = 21'd2,
    S_DCHK = 21'd4,
    S_DIV  = 21'd8,
    S_SUM  = 21'd16,
    S_NEG  = 21'd32,
    S_SQRT = 21'd64,
    S_CLIP = 21'd128,
    S_ESQ  = 21'd256,
    S_EHI  = 21'd512,
    S_ELO  = 21'd1024,
    S_EADD = 21'd2048,
    S_LMAG = 21'd4096,
    S_NSQ  = 21'd8192,
    S_LEN  = 21'd16384,
    S_AXD  = 21'd32768,
    S_MHI  = 21'd65536,
    S_MLO  = 21'd131072,
    S_MADD = 21'd262144,
    S_MNEG = 21'd524288,
    S_DONE = 21'd1048576
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        wneg_r, wneg_nxt;
  logic [31:0] wmag_r, wmag_nxt;
  logic        vneg_r, vneg_nxt;
  logic [31:0] vmag_r, vmag_nxt;
  logic [63:0] ma_r, ma_nxt;
  logic [63:0] d_r, d_nxt;
  logic [63:0] m_r, m_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [62:0] q_r, q_nxt;
  logic [31:0] dvsr_r, dvsr_nxt;
  logic        axph_r, axph_nxt;
  logic        sres_r, sres_nxt;
  logic        sat_r, sat_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] ph_r, ph_nxt;
  logic [63:0] pl_r, pl_nxt;
  logic [47:0] energy_r, energy_nxt;
  logic [63:0] lmag_r, lmag_nxt;
  logic [31:0] n2_r, n2_nxt;
  logic [31:0] len_r, len_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [30:0] u_r, u_nxt;
  logic [47:0] mom_r [3];
  logic [47:0] mom_nxt [3];
  logic [31:0] speed_r, speed_nxt;
  logic [31:0] inertia_r;
  logic [15:0] ax_r [3];
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] o_speed_r, o_speed_nxt;
  logic [47:0] o_energy_r, o_energy_nxt;
  logic [47:0] o_mom_r [3];
  logic [47:0] o_mom_nxt [3];
  logic        o_sat_r, o_sat_nxt;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  logic [15:0] ax_sel;
  logic [15:0] amag;
  logic [32:0] shifted;
  logic        qbit;
  logic [32:0] r33;
  logic [31:0] rr;
  logic        sb;

  wesu_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign ax_sel = ax_r[k_r];
  assign amag   = ax_sel[15] ? 16'(-ax_sel) : ax_sel;
  assign shifted = {rem_r, q_r[62]};
  assign r33    = res_r[32:0];
  assign sb     = ~wneg_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    wneg_nxt   = wneg_r;
    wmag_nxt   = wmag_r;
    vneg_nxt   = vneg_r;
    vmag_nxt   = vmag_r;
    ma_nxt     = ma_r;
    d_nxt      = d_r;
    m_nxt      = m_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    dvsr_nxt   = dvsr_r;
    axph_nxt   = axph_r;
    sres_nxt   = sres_r;
    sat_nxt    = sat_r;
    acc_nxt    = acc_r;
    ph_nxt     = ph_r;
    pl_nxt     = pl_r;
    energy_nxt = energy_r;
    lmag_nxt   = lmag_r;
    n2_nxt     = n2_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    u_nxt      = u_r;
    mom_nxt    = mom_r;
    speed_nxt  = speed_r;
    out_valid_nxt = out_valid_r;
    o_speed_nxt   = o_speed_r;
    o_energy_nxt  = o_energy_r;
    o_mom_nxt     = o_mom_r;
    o_sat_nxt     = o_sat_r;
    alu_req.op = ALU_ADD;
    alu_req.a  = 64'd0;
    alu_req.b  = 64'd0;
    qbit = 1'b0;
    rr   = 32'd0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wneg_nxt  = in_work_in[31];
          wmag_nxt  = in_work_in[31] ? 32'(-in_work_in) : in_work_in;
          vneg_nxt  = speed_r[31];
          vmag_nxt  = speed_r[31] ? 32'(32'd0 - speed_r) : speed_r;
          sat_nxt   = 1'b0;
          state_nxt = S_SQV;
        end
      end
      S_SQV: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, vmag_r};
        alu_req.b  = {32'd0, vmag_r};
        ma_nxt     = alu_rsp.y;
        state_nxt  = S_DCHK;
      end
      S_DCHK: begin
        // quotient reaches 2^63 exactly when the top dividend bits reach the divisor
        if (wmag_r == 32'd0) begin
          d_nxt     = 64'd0;
          state_nxt = S_SUM;
        end else if (inertia_r == 32'd0 || {18'd0, wmag_r[31:18]} >= inertia_r) begin
          d_nxt     = D_CLAMP;
          state_nxt = S_SUM;
        end else begin
          rem_nxt   = {18'd0, wmag_r[31:18]};
          q_nxt     = {wmag_r[17:0], 45'd0};
          dvsr_nxt  = inertia_r;
          cnt_nxt   = 6'd62;
          axph_nxt  = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {31'd0, shifted};
        alu_req.b  = {32'd0, dvsr_r};
        qbit       = ~alu_rsp.c;
        rem_nxt    = qbit ? alu_rsp.y[31:0] : shifted[31:0];
        q_nxt      = {q_r[61:0], qbit};
        cnt_nxt    = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (!axph_r) begin
            d_nxt     = {1'b0, q_nxt};
            state_nxt = S_SUM;
          end else begin
            u_nxt     = (q_nxt[30:0] > U_MAX) ? U_MAX : q_nxt[30:0];
            state_nxt = S_MHI;
          end
        end
      end
      S_SUM: begin
        alu_req.a = ma_r;
        alu_req.b = d_r;
        res_nxt   = 64'd0;
        bit_nxt   = SQRT_BIT0;
        cnt_nxt   = 6'd31;
        axph_nxt  = 1'b0;
        sres_nxt  = vneg_r;
        if (d_r == 64'd0 || sb == vneg_r) begin
          alu_req.op = ALU_ADD;
          m_nxt      = alu_rsp.y;
          state_nxt  = S_SQRT;
        end else begin
          alu_req.op = ALU_SUB;
          if (!alu_rsp.c) begin
            m_nxt     = alu_rsp.y;
            state_nxt = S_SQRT;
          end else begin
            // work outweighs the stored energy: direction reverses
            sres_nxt  = sb;
            state_nxt = S_NEG;
          end
        end
      end
      S_NEG: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = d_r;
        alu_req.b  = ma_r;
        m_nxt      = alu_rsp.y;
        state_nxt  = S_SQRT;
      end
      S_SQRT: begin
        // res and bit never overlap, so res|bit is res+bit
        alu_req.op = ALU_SUB;
        alu_req.a  = m_r;
        alu_req.b  = res_r | bit_r;
        if (!alu_rsp.c) begin
          m_nxt   = alu_rsp.y;
          res_nxt = (res_r >> 1) | bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = axph_r ? S_LEN : S_CLIP;
        end
      end
      S_CLIP: begin
        if (sres_r) begin
          if (r33 > 33'h0_8000_0000) begin
            rr      = 32'h8000_0000;
            sat_nxt = 1'b1;
          end else begin
            rr = r33[31:0];
          end
          speed_nxt = 32'd0 - rr;
        end else begin
          if (r33 > 33'h0_7FFF_FFFF) begin
            rr      = 32'h7FFF_FFFF;
            sat_nxt = 1'b1;
          end else begin
            rr = r33[31:0];
          end
          speed_nxt = rr;
        end
        vmag_nxt  = rr;
        vneg_nxt  = sres_r;
        state_nxt = S_ESQ;
      end
      S_ESQ: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, vmag_r};
        alu_req.b  = {32'd0, vmag_r};
        acc_nxt    = alu_rsp.y;
        state_nxt  = S_EHI;
      end
      S_EHI: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, acc_r[63:32]};
        alu_req.b  = {32'd0, inertia_r};
        ph_nxt     = alu_rsp.y;
        state_nxt  = S_ELO;
      end
      S_ELO: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, acc_r[31:0]};
        alu_req.b  = {32'd0, inertia_r};
        pl_nxt     = alu_rsp.y;
        state_nxt  = S_EADD;
      end
      S_EADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ph_r;
        alu_req.b  = {32'd0, pl_r[63:32]};
        if (|alu_rsp.y[63:61]) begin
          energy_nxt = E_MAX;
          sat_nxt    = 1'b1;
        end else begin
          energy_nxt = alu_rsp.y[60:13];
        end
        state_nxt = S_LMAG;
      end
      S_LMAG: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, vmag_r};
        alu_req.b  = {32'd0, inertia_r};
        lmag_nxt   = alu_rsp.y;
        k_nxt      = 2'd0;
        n2_nxt     = 32'd0;
        state_nxt  = S_NSQ;
      end
      S_NSQ: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {48'd0, amag};
        alu_req.b  = {48'd0, amag};
        n2_nxt     = n2_r + alu_rsp.y[31:0];
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          m_nxt     = {n2_nxt, 32'd0};
          res_nxt   = 64'd0;
          bit_nxt   = SQRT_BIT0;
          cnt_nxt   = 6'd31;
          axph_nxt  = 1'b1;
          state_nxt = S_SQRT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_LEN: begin
        len_nxt   = res_r[31:0];
        k_nxt     = 2'd0;
        state_nxt = S_AXD;
      end
      S_AXD: begin
        if (len_r == 32'd0) begin
          mom_nxt[k_r] = 48'd0;
          if (k_r == 2'd2) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end else if ({1'b0, amag, 15'd0} >= len_r) begin
          u_nxt     = U_MAX;
          state_nxt = S_MHI;
        end else begin
          rem_nxt   = {1'b0, amag, 15'd0};
          q_nxt     = 63'd0;
          dvsr_nxt  = len_r;
          cnt_nxt   = 6'd30;
          state_nxt = S_DIV;
        end
      end
      S_MHI: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, lmag_r[63:32]};
        alu_req.b  = {33'd0, u_r};
        ph_nxt     = alu_rsp.y;
        state_nxt  = S_MLO;
      end
      S_MLO: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {32'd0, lmag_r[31:0]};
        alu_req.b  = {33'd0, u_r};
        pl_nxt     = alu_rsp.y;
        state_nxt  = S_MADD;
      end
      S_MADD: begin
        alu_req.op   = ALU_ADD;
        alu_req.a    = ph_r;
        alu_req.b    = {32'd0, pl_r[63:32]};
        mom_nxt[k_r] = {2'd0, alu_rsp.y[63:18]};
        if (ax_sel[15] != vneg_r) begin
          state_nxt = S_MNEG;
        end else if (k_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_AXD;
        end
      end
      S_MNEG: begin
        alu_req.op   = ALU_SUB;
        alu_req.a    = 64'd0;
        alu_req.b    = {16'd0, mom_r[k_r]};
        mom_nxt[k_r] = alu_rsp.y[47:0];
        if (k_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_AXD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_speed_nxt   = speed_r;
          o_energy_nxt  = energy_r;
          o_mom_nxt     = mom_r;
          o_sat_nxt     = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      k_r         <= 2'd0;
      axph_r      <= 1'b0;
      speed_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      axph_r      <= axph_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wneg_r     <= wneg_nxt;
    wmag_r     <= wmag_nxt;
    vneg_r     <= vneg_nxt;
    vmag_r     <= vmag_nxt;
    ma_r       <= ma_nxt;
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    dvsr_r     <= dvsr_nxt;
    sres_r     <= sres_nxt;
    sat_r      <= sat_nxt;
    acc_r      <= acc_nxt;
    ph_r       <= ph_nxt;
    pl_r       <= pl_nxt;
    energy_r   <= energy_nxt;
    lmag_r     <= lmag_nxt;
    n2_r       <= n2_nxt;
    len_r      <= len_nxt;
    u_r        <= u_nxt;
    mom_r      <= mom_nxt;
    o_speed_r  <= o_speed_nxt;
    o_energy_r <= o_energy_nxt;
    o_mom_r    <= o_mom_nxt;
    o_sat_r    <= o_sat_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r <= INERTIA_RST;
      ax_r[0]   <= AXIS_X_RST;
      ax_r[1]   <= 16'd0;
      ax_r[2]   <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INERTIA: inertia_r <= cfg_wdata;
        CFG_AXIS_X:  ax_r[0]   <= cfg_wdata[15:0];
        CFG_AXIS_Y:  ax_r[1]   <= cfg_wdata[15:0];
        CFG_AXIS_Z:  ax_r[2]   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_speed_out  = o_speed_r;
  assign out_energy_out = o_energy_r;
  assign out_momentum_x = o_mom_r[0];
  assign out_momentum_y = o_mom_r[1];
  assign out_momentum_z = o_mom_r[2];
  assign out_saturated  = o_sat_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SQV))
    else $error("accepted transaction did not start the sequence");

  a_speed_only_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLIP) |=> $stable(speed_r))
    else $error("wheel speed changed outside the clip step");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLIP) |-> (res_r[63:32] == 32'd0))
    else $error("square root wider than 32 bits");

  a_unit_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MHI) |-> (u_r <= U_MAX))
    else $error("unit axis component above one");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == S_IDLE && o_speed_r == speed_r))
    else $error("result not presented after completion");

endmodule

// File: test/wesu_checker.sv
// transaction monitor, speed/energy/momentum predictor and result comparator
module wesu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_work_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_speed_out,
  input  logic        [47:0] out_energy_out,
  input  logic signed [47:0] out_momentum_x,
  input  logic signed [47:0] out_momentum_y,
  input  logic signed [47:0] out_momentum_z,
  input  logic               out_saturated,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_wdata,
  output int                 fail_count,
  output int                 work_accepted,
  output int                 results_seen,
  output int                 results_pending,
  output int                 sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import wesu_pkg::*;

  typedef struct packed {
    logic signed [31:0] speed;
    logic        [47:0] energy;
    logic signed [47:0] mom_x;
    logic signed [47:0] mom_y;
    logic signed [47:0] mom_z;
    logic               sat;
  } wheel_result_t;

  logic        [31:0] inertia_q;
  logic signed [15:0] axis_q [3];
  logic        [31:0] speed_q;
  wheel_result_t      expected_results [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] m);
    logic [63:0] res;
    logic [63:0] bit_v;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > m) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (m >= res + bit_v) begin
        m   = m - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // advance the wheel by one work value and form the result
  function automatic wheel_result_t apply_work(input logic [31:0] work);
    wheel_result_t r;
    logic          wneg, vneg, sb, sres;
    logic [63:0]   wmag, vmag, ma, d, m, x, q1, r1, root, n2, len, amag, u;
    logic [127:0]  wide;
    logic [47:0]   p;
    logic [63:0]   mom [3];
    wneg = work[31];
    wmag = wneg ? 64'(32'(0 - work)) : 64'(work);
    vneg = speed_q[31];
    vmag = vneg ? 64'(32'(0 - speed_q)) : 64'(speed_q);
    ma   = vmag * vmag;
    r.sat = 1'b0;
    if (wmag == 0) d = '0;
    else if (inertia_q == 0) d = D_CLAMP;
    else begin
      x  = wmag << 13;
      q1 = x / inertia_q;
      r1 = x % inertia_q;
      if (q1 >= 64'h8000_0000) d = D_CLAMP;
      else d = (q1 << 32) + (r1 << 32) / inertia_q;
    end
    sb = !wneg;
    if (d == 0 || sb == vneg) begin
      m = ma + d; sres = vneg;
    end else if (ma >= d) begin
      m = ma - d; sres = vneg;
    end else begin
      m = d - ma; sres = sb;
    end
    if (m == 0) sres = 1'b0;
    root = int_sqrt(m);
    if (sres) begin
      if (root > 64'h8000_0000) begin root = 64'h8000_0000; r.sat = 1'b1; end
      speed_q = 32'(0 - root[31:0]);
    end else begin
      if (root > 64'h7FFF_FFFF) begin root = 64'h7FFF_FFFF; r.sat = 1'b1; end
      speed_q = root[31:0];
    end
    vmag = root;
    wide = (128'(vmag * vmag) * inertia_q) >> 45;
    if (wide > 128'(E_MAX)) begin r.energy = E_MAX; r.sat = 1'b1; end
    else r.energy = wide[47:0];
    r.speed = speed_q;
    n2 = '0;
    for (int k = 0; k < 3; k++) n2 = n2 + 64'(longint'(axis_q[k]) * longint'(axis_q[k]));
    len = int_sqrt(n2 << 32);
    for (int k = 0; k < 3; k++) begin
      mom[k] = '0;
      if (len != 0) begin
        amag = axis_q[k][15] ? 64'(-longint'(axis_q[k])) : 64'(axis_q[k]);
        u = (amag << 46) / len;
        if (u > 64'(U_MAX)) u = 64'(U_MAX);
        wide = (128'(vmag * inertia_q) * u) >> 50;
        p = wide[47:0];
        mom[k] = (axis_q[k][15] != sres) ? 64'(48'(0 - p)) : 64'(p);
      end
    end
    r.mom_x = mom[0][47:0];
    r.mom_y = mom[1][47:0];
    r.mom_z = mom[2][47:0];
    return r;
  endfunction

  assign results_pending = expected_results.size();

  always @(posedge clk) begin
    wheel_result_t e;
    if (!rst_n) begin
      inertia_q <= INERTIA_RST;
      axis_q[0] <= AXIS_X_RST;
      axis_q[1] <= '0;
      axis_q[2] <= '0;
      speed_q   = '0;
      expected_results.delete();
      fail_count    <= 0;
      work_accepted <= 0;
      results_seen  <= 0;
      sat_seen      <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_INERTIA: inertia_q <= cfg_wdata;
          CFG_AXIS_X:  axis_q[0] <= cfg_wdata[15:0];
          CFG_AXIS_Y:  axis_q[1] <= cfg_wdata[15:0];
          CFG_AXIS_Z:  axis_q[2] <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_work(in_work_in));
        work_accepted <= work_accepted + 1;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_saturated) sat_seen <= sat_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if ({out_speed_out, out_energy_out, out_momentum_x, out_momentum_y,
               out_momentum_z, out_saturated} != e)
            fail_count <= fail_count + 1;
          if (out_speed_out != e.speed)
            $error("speed_out expected %0d got %0d", e.speed, out_speed_out);
          if (out_energy_out != e.energy)
            $error("energy_out expected %0d got %0d", e.energy, out_energy_out);
          if (out_momentum_x != e.mom_x)
            $error("momentum_x expected %0d got %0d", e.mom_x, out_momentum_x);
          if (out_momentum_y != e.mom_y)
            $error("momentum_y expected %0d got %0d", e.mom_y, out_momentum_y);
          if (out_momentum_z != e.mom_z)
            $error("momentum_z expected %0d got %0d", e.mom_z, out_momentum_z);
          if (out_saturated != e.sat)
            $error("saturated expected %0b got %0b", e.sat, out_saturated);
        end
      end
    end
  end

endmodule

// File: test/tb_wheel_energy_speed_update.sv
// stimulus, clocking and verdict for the wheel energy/speed update block
module tb_wheel_energy_speed_update;
  timeunit 1ns;
  timeprecision 1ps;
  import wesu_pkg::*;

  localparam int IDLE_PCT    = 29;
  localparam int QUIET_START = 120000;
  localparam int QUIET_END   = 180000;
  localparam int HOLD_START  = 30000;
  localparam int HOLD_LEN    = 3000;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN       = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_work_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_speed_out;
  logic        [47:0] out_energy_out;
  logic signed [47:0] out_momentum_x, out_momentum_y, out_momentum_z;
  logic               out_saturated;
  logic               cfg_we = 1'b0;
  logic        [1:0]  cfg_index = CFG_INERTIA;
  logic        [31:0] cfg_wdata = '0;

  int fail_count, work_accepted, results_seen, results_pending, sat_seen;
  int cycle_cnt = 0;
  int work_sent = 0;
  int phases_run = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  wheel_energy_speed_update i_dut (.*);

  wesu_checker i_checker (.*);

  function automatic logic quiet();
    return cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END;
  endfunction

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (cycle_cnt == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (quiet()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_work(input logic [31:0] w);
    while (!quiet() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_work_in <= w;
    work_sent++;
    do @(negedge clk); while (work_accepted < work_sent);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] inert, input logic [15:0] ax,
                            input logic [15:0] ay, input logic [15:0] az);
    wait_idle();
    write_reg(CFG_INERTIA, inert);
    write_reg(CFG_AXIS_X, {{16{ax[15]}}, ax});
    write_reg(CFG_AXIS_Y, {{16{ay[15]}}, ay});
    write_reg(CFG_AXIS_Z, {{16{az[15]}}, az});
    phases_run++;
  endtask

  // mostly small signed work of random magnitude, some zero and full range
  function automatic logic [31:0] random_work();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 20) return $urandom;
    return 32'($signed($urandom) >>> $urandom_range(0, 31));
  endfunction

  // no-progress watchdog
  initial begin
    int idle_cycles, last_total;
    idle_cycles = 0;
    last_total  = 0;
    forever begin
      @(negedge clk);
      if (work_accepted + results_seen != last_total) begin
        last_total  = work_accepted + results_seen;
        idle_cycles = 0;
      end else if (++idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed [$];
    directed = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                 32'hFFFF_FFFF, 32'h0, 32'h0001_0000,
                 32'hFFFE_0000, 32'hFFFE_0000, 32'h0004_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h0};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration: zero work, extremes, reversals both ways
    foreach (directed[i]) send_work(directed[i]);

    // smallest inertia: large work can saturate speed
    set_config(32'h1, 16'h8000, 16'h7FFF, 16'h0);
    foreach (directed[i]) send_work(directed[i]);

    // largest inertia, zero axis gives zero momentum
    set_config(32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0);
    foreach (directed[i]) send_work(directed[i]);

    set_config(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    repeat (150) send_work(random_work());

    for (int ph = 0; ph < 9; ph++) begin
      set_config((ph % 3 == 0) ? 32'(1 << $urandom_range(0, 31)) : $urandom,
                 16'($urandom), 16'($urandom), (ph == 4) ? 16'h0 : 16'($urandom));
      repeat (160) send_work(random_work());
    end

    wait_idle();
    $display("%0d work values over %0d register settings, %0d results, %0d saturated",
             work_accepted, phases_run + 1, results_seen, sat_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
